// ===== rtl/core/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// shared types and constants for the ray versus box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   // dividend magnitude: 33 bit difference scaled by the fraction bits
   localparam int DIV_W     = DATA_W + 1 + FRAC_BITS;
   // signed quotient plus headroom for the unbounded marker
   localparam int QUO_W     = DIV_W + 2;
   // divider depth: one stage per quotient bit plus the sign stage
   localparam int DIV_LAT   = DIV_W + 1;
   localparam int AXES      = 3;
   localparam int LANES     = 2 * AXES;

   localparam logic signed [QUO_W-1:0] T_INF     = QUO_W'(1) <<< DIV_W;
   localparam logic signed [QUO_W-1:0] T_NEG_INF = -T_INF;
   localparam logic signed [QUO_W-1:0] SAT_MAX   = QUO_W'(32'sh7fff_ffff);
   localparam logic signed [QUO_W-1:0] SAT_MIN   = -SAT_MAX - QUO_W'(1);

   typedef struct packed {
      logic signed [DATA_W-1:0] origin_x;
      logic signed [DATA_W-1:0] origin_y;
      logic signed [DATA_W-1:0] origin_z;
      logic signed [DATA_W-1:0] dir_x;
      logic signed [DATA_W-1:0] dir_y;
      logic signed [DATA_W-1:0] dir_z;
      logic signed [DATA_W-1:0] box_min_x;
      logic signed [DATA_W-1:0] box_min_y;
      logic signed [DATA_W-1:0] box_min_z;
      logic signed [DATA_W-1:0] box_max_x;
      logic signed [DATA_W-1:0] box_max_y;
      logic signed [DATA_W-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] t_enter;
      logic signed [DATA_W-1:0] t_exit;
   } rsp_type;

   // per axis flags that ride alongside the dividers
   typedef struct packed {
      logic [AXES-1:0] ok;
      logic [AXES-1:0] unb;
   } meta_type;

endpackage

// ===== rtl/core/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div
// pipelined restoring divider, one quotient bit per stage, signed result
// ----------------------------------------------------------------------------
module rbst_div (
   input  logic                                   clock,
   input  logic [rbst_pkg::DIV_W-1:0]             dvd,
   input  logic [rbst_pkg::DATA_W-1:0]            dsr,
   input  logic                                   neg,
   output logic signed [rbst_pkg::QUO_W-1:0]      quo
);
   import rbst_pkg::*;

   logic [DATA_W-1:0] rem_ff [DIV_W];
   logic [DATA_W-1:0] rem_in [DIV_W];
   logic [DIV_W-1:0]  num_ff [DIV_W];
   logic [DIV_W-1:0]  num_in [DIV_W];
   logic [DATA_W-1:0] dsr_ff [DIV_W];
   logic [DATA_W-1:0] dsr_in [DIV_W];
   logic              neg_ff [DIV_W];
   logic              neg_in [DIV_W];
   logic signed [QUO_W-1:0] quo_ff;
   logic signed [QUO_W-1:0] quo_in;

   always_comb begin
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;
      logic [DATA_W-1:0] rem_src;
      logic [DIV_W-1:0]  num_src;
      logic [DATA_W-1:0] dsr_src;
      logic              neg_src;
      for (int i = 0; i < DIV_W; i++) begin
         if (i == 0) begin
            rem_src = '0;
            num_src = dvd;
            dsr_src = dsr;
            neg_src = neg;
         end else begin
            rem_src = rem_ff[i-1];
            num_src = num_ff[i-1];
            dsr_src = dsr_ff[i-1];
            neg_src = neg_ff[i-1];
         end
         trial = {rem_src, num_src[DIV_W-1]};
         diff  = trial - {1'b0, dsr_src};
         if (trial >= {1'b0, dsr_src}) begin
            rem_in[i] = diff[DATA_W-1:0];
            num_in[i] = {num_src[DIV_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[DATA_W-1:0];
            num_in[i] = {num_src[DIV_W-2:0], 1'b0};
         end
         dsr_in[i] = dsr_src;
         neg_in[i] = neg_src;
      end
   end

   // apply the sign, truncation toward zero comes from the magnitude divide
   always_comb begin
      if (neg_ff[DIV_W-1]) begin
         quo_in = -$signed({2'b00, num_ff[DIV_W-1]});
      end else begin
         quo_in = $signed({2'b00, num_ff[DIV_W-1]});
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_W; i++) begin
         rem_ff[i] <= rem_in[i];
         num_ff[i] <= num_in[i];
         dsr_ff[i] <= dsr_in[i];
         neg_ff[i] <= neg_in[i];
      end
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/core/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test
// ray versus axis aligned box slab test, fully pipelined
// ----------------------------------------------------------------------------
// takes one request per clock (busy is never raised) and returns one result
// per request in order; the latency is set by the six pipelined dividers,
// one quotient bit per stage; the receiver cannot stall, so each result is
// shown for one cycle with rsp_valid high
module ray_box_slab_test (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rbst_pkg::req_type req_item,
   output logic              rsp_valid,
   output rbst_pkg::rsp_type rsp_item
);
   import rbst_pkg::*;

   // stage 1: capture the request
   req_type in_ff;
   logic    v1_ff;

   // stage 2: differences and slab flags, feed the dividers
   logic signed [DATA_W-1:0] org [AXES];
   logic signed [DATA_W-1:0] dir [AXES];
   logic signed [DATA_W-1:0] lo  [AXES];
   logic signed [DATA_W-1:0] hi  [AXES];
   logic [DIV_W-1:0]  dvd [LANES];
   logic [DATA_W-1:0] dsr [LANES];
   logic              neg [LANES];
   logic signed [QUO_W-1:0] quo [LANES];
   meta_type meta_in;

   // flag delay line matching the divider latency
   meta_type meta_ff [DIV_LAT];
   logic     vd_ff   [DIV_LAT];

   // stage 3: ordered slab interval per axis
   logic signed [QUO_W-1:0] a3_ff [AXES];
   logic signed [QUO_W-1:0] b3_ff [AXES];
   logic signed [QUO_W-1:0] a3_in [AXES];
   logic signed [QUO_W-1:0] b3_in [AXES];
   logic                    ok3_ff;
   logic                    v3_ff;

   // stage 4: intersected interval
   logic signed [QUO_W-1:0] tin_ff, tout_ff, tin_in, tout_in;
   logic                    ok4_ff;
   logic                    v4_ff;

   // stage 5: result register
   rsp_type out_ff, out_in;
   logic    vo_ff;

   assign busy = 1'b0;

   assign org[0] = in_ff.origin_x;    assign org[1] = in_ff.origin_y;
   assign org[2] = in_ff.origin_z;
   assign dir[0] = in_ff.dir_x;       assign dir[1] = in_ff.dir_y;
   assign dir[2] = in_ff.dir_z;
   assign lo[0]  = in_ff.box_min_x;   assign lo[1]  = in_ff.box_min_y;
   assign lo[2]  = in_ff.box_min_z;
   assign hi[0]  = in_ff.box_max_x;   assign hi[1]  = in_ff.box_max_y;
   assign hi[2]  = in_ff.box_max_z;

   // lanes 0..2 divide the lower bounds, lanes 3..5 the upper bounds
   always_comb begin
      logic signed [DATA_W:0]   diff;
      logic [DATA_W:0]          mag;
      logic [DATA_W-1:0]        dmag;
      logic signed [DATA_W-1:0] bnd;
      int                       ax;
      for (int k = 0; k < LANES; k++) begin
         ax   = k % AXES;
         bnd  = (k < AXES) ? lo[ax] : hi[ax];
         diff = {bnd[DATA_W-1], bnd} - {org[ax][DATA_W-1], org[ax]};
         mag  = diff[DATA_W] ? -diff : diff;
         dmag = dir[ax][DATA_W-1] ? -dir[ax] : dir[ax];
         dvd[k] = {mag, {FRAC_BITS{1'b0}}};
         dsr[k] = dmag;
         neg[k] = diff[DATA_W] ^ dir[ax][DATA_W-1];
      end
      // a zero direction gives an unbounded slab when the origin lies inside
      for (int j = 0; j < AXES; j++) begin
         meta_in.unb[j] = (dir[j] == '0);
         meta_in.ok[j]  = (dir[j] != '0) || (lo[j] <= org[j] && org[j] <= hi[j]);
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      rbst_div u_div (
         .clock (clock),
         .dvd   (dvd[k]),
         .dsr   (dsr[k]),
         .neg   (neg[k]),
         .quo   (quo[k])
      );
   end

   // order each pair, or open the slab fully on a zero direction
   always_comb begin
      for (int j = 0; j < AXES; j++) begin
         if (meta_ff[DIV_LAT-1].unb[j]) begin
            a3_in[j] = T_NEG_INF;
            b3_in[j] = T_INF;
         end else if (quo[j] > quo[j+AXES]) begin
            a3_in[j] = quo[j+AXES];
            b3_in[j] = quo[j];
         end else begin
            a3_in[j] = quo[j];
            b3_in[j] = quo[j+AXES];
         end
      end
   end

   // latest entry and earliest exit over the three slabs
   always_comb begin
      tin_in  = (a3_ff[0] > a3_ff[1]) ? a3_ff[0] : a3_ff[1];
      if (a3_ff[2] > tin_in) begin
         tin_in = a3_ff[2];
      end
      tout_in = (b3_ff[0] < b3_ff[1]) ? b3_ff[0] : b3_ff[1];
      if (b3_ff[2] < tout_in) begin
         tout_in = b3_ff[2];
      end
   end

   // touching intervals count as a hit, a miss reports zero distances
   always_comb begin
      out_in = '0;
      if (ok4_ff && tin_ff <= tout_ff) begin
         out_in.hit = 1'b1;
         if (tin_ff > SAT_MAX) begin
            out_in.t_enter = SAT_MAX[DATA_W-1:0];
         end else if (tin_ff < SAT_MIN) begin
            out_in.t_enter = SAT_MIN[DATA_W-1:0];
         end else begin
            out_in.t_enter = tin_ff[DATA_W-1:0];
         end
         if (tout_ff > SAT_MAX) begin
            out_in.t_exit = SAT_MAX[DATA_W-1:0];
         end else if (tout_ff < SAT_MIN) begin
            out_in.t_exit = SAT_MIN[DATA_W-1:0];
         end else begin
            out_in.t_exit = tout_ff[DATA_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff <= req_item;
      meta_ff[0] <= meta_in;
      for (int i = 1; i < DIV_LAT; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
      for (int j = 0; j < AXES; j++) begin
         a3_ff[j] <= a3_in[j];
         b3_ff[j] <= b3_in[j];
      end
      ok3_ff  <= &meta_ff[DIV_LAT-1].ok;
      tin_ff  <= tin_in;
      tout_ff <= tout_in;
      ok4_ff  <= ok3_ff;
      out_ff  <= out_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff    <= start & ~busy;
         vd_ff[0] <= v1_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         v3_ff <= vd_ff[DIV_LAT-1];
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_item  = out_ff;

endmodule
